### hdl/uptc_pkg.sv
// ----------------------------------------------------------------------------
// uptc_pkg
// Shared types and byte constants for the printable UTF-8 text checker.
// ----------------------------------------------------------------------------
package uptc_pkg;

  // Scan state carried from one byte to the next within a text.
  typedef struct packed {
    logic [1:0] pending;  // continuation bytes still expected
    logic       failed;   // sticky failure flag
  } scan_state_t;

  localparam logic [7:0] AsciiLimit  = 8'h80;
  localparam logic [7:0] PrintLow    = 8'h20;
  localparam logic [7:0] DelChar     = 8'h7F;
  localparam logic [7:0] Lead2Low    = 8'hC2;
  localparam logic [7:0] Lead2High   = 8'hDF;
  localparam logic [7:0] Lead3Low    = 8'hE0;
  localparam logic [7:0] Lead3High   = 8'hEF;
  localparam logic [7:0] Lead4Low    = 8'hF0;
  localparam logic [7:0] Lead4High   = 8'hF4;
  localparam logic [7:0] ContMask    = 8'hC0;
  localparam logic [7:0] ContPattern = 8'h80;

  // Number of continuation bytes opened by a lead byte; zero for a bad lead.
  function automatic logic [1:0] followers_of(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if (b >= Lead2Low && b <= Lead2High) n = 2'd1;
    else if (b >= Lead3Low && b <= Lead3High) n = 2'd2;
    else if (b >= Lead4Low && b <= Lead4High) n = 2'd3;
    return n;
  endfunction

endpackage

### hdl/uptc_byte_check.sv
// ----------------------------------------------------------------------------
// uptc_byte_check
// Next-state and verdict logic for one text item.
// ----------------------------------------------------------------------------
module uptc_byte_check (
  input  uptc_pkg::scan_state_t state_i,
  input  logic [7:0]            text_byte_i,
  input  logic                  byte_present_i,
  input  logic                  end_of_text_i,
  output uptc_pkg::scan_state_t state_o,
  output logic                  printable_o
);

  uptc_pkg::scan_state_t after_byte;

  always_comb begin
    after_byte = state_i;
    if (byte_present_i && !state_i.failed) begin
      if (state_i.pending != 2'd0) begin
        if ((text_byte_i & uptc_pkg::ContMask) != uptc_pkg::ContPattern) begin
          after_byte.failed = 1'b1;
        end else begin
          after_byte.pending = state_i.pending - 2'd1;
        end
      end else if (text_byte_i < uptc_pkg::AsciiLimit) begin
        if (text_byte_i < uptc_pkg::PrintLow || text_byte_i == uptc_pkg::DelChar) begin
          after_byte.failed = 1'b1;
        end
      end else if (uptc_pkg::followers_of(text_byte_i) == 2'd0) begin
        after_byte.failed = 1'b1;
      end else begin
        after_byte.pending = uptc_pkg::followers_of(text_byte_i);
      end
    end
  end

  assign printable_o = !after_byte.failed && (after_byte.pending == 2'd0);

  // The state starts over after every end of text.
  always_comb begin
    if (end_of_text_i) begin
      state_o = '0;
    end else begin
      state_o = after_byte;
    end
  end

endmodule

### hdl/uptc_out_stage.sv
// ----------------------------------------------------------------------------
// uptc_out_stage
// Result register that holds a verdict until the consumer takes it.
// ----------------------------------------------------------------------------
module uptc_out_stage (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  logic printable_i,
  output logic free_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic printable_o
);

  logic valid_q, valid_d;
  logic data_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= printable_i;
    end
  end

  assign out_valid_o = valid_q;
  assign printable_o = data_q;

endmodule

### hdl/utf8_printable_text_checker_unit.sv
// ----------------------------------------------------------------------------
// utf8_printable_text_checker_unit
// Checks a byte stream for printable, well-formed UTF-8, one verdict per text.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake               Payload
//   -------  ----------------------  -------------------------------------------
//   input    in_valid_i/in_ready_o   text_byte_i, byte_present_i, end_of_text_i
//   output   out_valid_o/out_ready_i printable_o
//
// An accepted transaction lands in the input register; from there the byte
// check updates the scan state and, on an end of text, loads the verdict
// into the result register. One transaction per cycle is sustained while
// no end-of-text transaction waits for the result register.
// Reset clears the scan state and both valid flags. Only an end-of-text
// transaction waits for a full result register; while it waits, the input
// register holds and in_ready_o falls, so the input side stalls behind it.
//
module utf8_printable_text_checker_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       byte_present_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       printable_o
);

  // Input register.
  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       present_q;
  logic       end_q;

  // Scan state across the bytes of one text.
  uptc_pkg::scan_state_t state_q, state_d;

  logic out_free;
  logic verdict;
  logic advance;

  // The registered transaction moves on unless it carries a verdict and the
  // result register is still occupied.
  assign advance    = in_valid_q && (!end_q || out_free);
  assign in_ready_o = !in_valid_q || advance;
  assign in_valid_d = (in_valid_i && in_ready_o) || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q    <= text_byte_i;
      present_q <= byte_present_i;
      end_q     <= end_of_text_i;
    end
  end

  uptc_byte_check u_check (
    .state_i        (state_q),
    .text_byte_i    (byte_q),
    .byte_present_i (present_q),
    .end_of_text_i  (end_q),
    .state_o        (state_d),
    .printable_o    (verdict)
  );

  uptc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && end_q),
    .printable_i (verdict),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .printable_o (printable_o)
  );

endmodule

### tb/sv/utf8_verdict_monitor.sv
// ----------------------------------------------------------------------------
// utf8_verdict_monitor
// Watches both channels of the text checker, predicts each verdict from the
// accepted input transactions and compares it with the verdict delivered.
// ----------------------------------------------------------------------------
module utf8_verdict_monitor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] text_byte_i,
  input  logic       byte_present_i,
  input  logic       end_of_text_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       printable_i,
  output int         fail_count_o,
  output int         open_verdicts_o
);

  uptc_pkg::scan_state_t scan_q = '0;
  logic                  verdict_q[$];
  int                    mismatch_cnt = 0;
  int                    open_cnt     = 0;

  assign fail_count_o    = mismatch_cnt;
  assign open_verdicts_o = open_cnt;

  // How many continuation bytes a lead byte announces; zero if it cannot lead.
  function automatic logic [1:0] sequence_tail(input logic [7:0] b);
    if (b >= uptc_pkg::Lead4Low && b <= uptc_pkg::Lead4High) return 2'd3;
    if (b >= uptc_pkg::Lead3Low && b <= uptc_pkg::Lead3High) return 2'd2;
    if (b >= uptc_pkg::Lead2Low && b <= uptc_pkg::Lead2High) return 2'd1;
    return 2'd0;
  endfunction

  function automatic uptc_pkg::scan_state_t scan_byte(input uptc_pkg::scan_state_t s,
                                                      input logic [7:0] b);
    uptc_pkg::scan_state_t n;
    n = s;
    if (s.failed) return n;
    if (s.pending != 2'd0) begin
      if ((b & uptc_pkg::ContMask) != uptc_pkg::ContPattern) n.failed = 1'b1;
      else n.pending = s.pending - 2'd1;
    end else if (b < uptc_pkg::AsciiLimit) begin
      if (b < uptc_pkg::PrintLow || b == uptc_pkg::DelChar) n.failed = 1'b1;
    end else if (sequence_tail(b) == 2'd0) begin
      n.failed = 1'b1;
    end else begin
      n.pending = sequence_tail(b);
    end
    return n;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    uptc_pkg::scan_state_t next_s;
    logic                  want;
    if (!rst_ni) begin
      scan_q = '0;
      verdict_q.delete();
      open_cnt = 0;
    end else begin
      // The verdict leaving now was predicted at an earlier edge.
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected verdict: expected none, got printable=%0b",
                   $time, printable_i);
        end else begin
          want = verdict_q.pop_front();
          open_cnt--;
          if (printable_i !== want) begin
            mismatch_cnt++;
            $display("%0t: printable mismatch: expected %0b, got %0b",
                     $time, want, printable_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        next_s = scan_q;
        if (byte_present_i) next_s = scan_byte(next_s, text_byte_i);
        if (end_of_text_i) begin
          want = !next_s.failed && next_s.pending == 2'd0;
          verdict_q = {verdict_q, want};
          open_cnt++;
          next_s = '0;
        end
        scan_q = next_s;
      end
    end
  end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives texts into the printable UTF-8 text checker and gives the verdict.
// A directed set of texts covers the byte class boundaries, every sequence
// length, bare markers, cut-short and broken sequences; random texts follow,
// mostly well formed, under three idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb;

  // Cycles of silence on both channels after which the run is declared hung.
  localparam int unsigned HangLimit   = 1000;
  // Cycles to wait once every predicted verdict has been delivered.
  localparam int unsigned DrainCycles = 10;
  // Minimum number of random input transactions sent under each idling pattern.
  localparam int unsigned PhaseItems  = 150;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [7:0] text_byte_i    = 8'h00;
  logic       byte_present_i = 1'b0;
  logic       end_of_text_i  = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic       printable_o;

  int          fail_count;
  int          open_verdicts;
  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 57;
  int unsigned sent_items    = 0;
  int unsigned quiet_cycles  = 0;
  logic [7:0]  text_q[$];

  utf8_printable_text_checker_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .text_byte_i    (text_byte_i),
    .byte_present_i (byte_present_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .printable_o    (printable_o)
  );

  utf8_verdict_monitor verdict_mon (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .text_byte_i     (text_byte_i),
    .byte_present_i  (byte_present_i),
    .end_of_text_i   (end_of_text_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .printable_i     (printable_o),
    .fail_count_o    (fail_count),
    .open_verdicts_o (open_verdicts)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver decides afresh at every falling edge whether to take a
  // verdict, so its stalls land on every phase of the block's pipeline.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Any accepted transaction on either channel counts as progress. Values
  // read here at the rising edge are the ones the block itself samples.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= HangLimit) begin
        $display("[utf8_printable_text_checker_unit] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Appends one byte to the text being built.
  function automatic void add_byte(input logic [7:0] b);
    text_q = {text_q, b};
  endfunction

  // Offers one transaction. The sender may idle first;
  // once valid rises it holds, with the payload, until the block takes it.
  // Every call starts and ends at a falling edge.
  task automatic send_item(input logic [7:0] b, input logic present, input logic last_item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    text_byte_i    <= b;
    byte_present_i <= present;
    end_of_text_i  <= last_item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_items++;
    @(negedge clk_i);
  endtask

  // Sends the bytes held in text_q as one text. The end is flagged either on
  // the last byte or by a bare end marker after it. With noise set, bare
  // items without an end are scattered between the bytes; the block must
  // pass over them without touching its scan state.
  task automatic send_text(input bit bare_end, input bit noise);
    bit end_alone;
    end_alone = bare_end || (text_q.size() == 0);
    foreach (text_q[i]) begin
      if (noise && $urandom_range(19) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(text_q[i], 1'b1, !end_alone && (i == text_q.size() - 1));
    end
    if (end_alone) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Builds a random text. Three quarters are well formed: printable ASCII
  // mixed with 2-, 3- and 4-byte sequences with random payload bits. The
  // rest are cut short at the end, carry one random byte in place of a good
  // one, or are plain random bytes.
  task automatic send_random_text();
    int unsigned flavor;
    int unsigned n_chars;
    int unsigned tail;
    int unsigned pos;
    flavor  = $urandom_range(99);
    n_chars = $urandom_range(6);
    text_q.delete();
    for (int c = 0; c < n_chars; c++) begin
      tail = $urandom_range(3);
      case (tail)
        0: add_byte(8'($urandom_range(8'h7E, 8'h20)));
        1: add_byte(8'($urandom_range(8'hDF, 8'hC2)));
        2: add_byte(8'($urandom_range(8'hEF, 8'hE0)));
        default: add_byte(8'($urandom_range(8'hF4, 8'hF0)));
      endcase
      repeat (tail) add_byte(8'h80 | 8'($urandom_range(8'h3F)));
    end
    if (flavor >= 93) begin
      text_q.delete();
      repeat ($urandom_range(6, 1)) add_byte(8'($urandom_range(255)));
    end else if (flavor >= 84) begin
      if (text_q.size() == 0) begin
        add_byte(8'($urandom_range(255)));
      end else begin
        pos = $urandom_range(text_q.size() - 1);
        text_q[pos] = 8'($urandom_range(255));
      end
    end else if (flavor >= 75) begin
      if (text_q.size() != 0) void'(text_q.pop_back());
    end
    send_text($urandom_range(3) == 0, 1'b1);
  endtask

  initial begin
    int unsigned phase_start;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed texts, run under the first idling pattern.
    send_item(8'hA5, 1'b0, 1'b1);              // empty text is printable
    send_item(8'h3C, 1'b0, 1'b0);              // bare item, no end: ignored
    text_q = {8'h41};
    send_text(1'b0, 1'b0);
    text_q = {8'h1F};                          // just below the printable range
    send_text(1'b0, 1'b0);
    text_q = {8'h20, 8'h7E};                   // lowest and highest printable ASCII
    send_text(1'b0, 1'b0);
    text_q = {8'h7F};                          // delete character
    send_text(1'b0, 1'b0);
    text_q = {8'hC1};                          // just below the 2-byte leads
    send_text(1'b0, 1'b0);
    text_q = {8'hF5};                          // just above the 4-byte leads
    send_text(1'b0, 1'b0);
    text_q = {8'hFF};
    send_text(1'b0, 1'b0);
    text_q = {8'h80};                          // stray continuation byte
    send_text(1'b0, 1'b0);
    text_q = {8'hC2, 8'h80, 8'hDF, 8'hBF};     // 2-byte lead edges
    send_text(1'b0, 1'b0);
    text_q = {8'hF4, 8'h8F, 8'hBF, 8'hBF};     // top 4-byte sequence
    send_text(1'b0, 1'b0);
    text_q = {8'hC2};                          // sequence cut short by the end
    send_text(1'b1, 1'b0);
    text_q = {8'hE0, 8'h41, 8'h00};            // bad follower, then bytes ignored
    send_text(1'b0, 1'b0);
    // A bare item inside a 3-byte sequence must not disturb it.
    send_item(8'hE0, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'hBF, 1'b1, 1'b1);

    // Random texts under the three idling patterns in turn.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_start = sent_items;
      while (sent_items - phase_start < PhaseItems) send_random_text();
    end
    in_valid_i <= 1'b0;

    // Let every predicted verdict arrive; the watchdog catches a hang.
    while (open_verdicts != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && open_verdicts == 0) begin
      $display("[utf8_printable_text_checker_unit] OK");
    end else begin
      $display("[utf8_printable_text_checker_unit] ERROR");
    end
    $finish;
  end

endmodule
